### rtl/i2csbr_pkg.sv
// ----------------------------------------------------------------------------
// i2csbr_pkg
// Types, codes and helpers shared by the sensor burst read sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2csbr_pkg;

	localparam int unsigned ADDR_W = 7;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned WIDX_W = 3;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam logic [ADDR_W-1:0] TARGET_ADDRESS_RST = 7'd104;
	localparam logic [BYTE_W-1:0] BURST_FIRST_RST = 8'h3B;

	// register byte addresses
	localparam logic [PADDR_W-1:0] REG_TARGET_ADDRESS = 3'd0;
	localparam logic [PADDR_W-1:0] REG_BURST_FIRST = 3'd4;

	typedef enum logic [1:0] {
		FN_WRITE = 2'd0,
		FN_READ  = 2'd1,
		FN_BURST = 2'd2,
		FN_EVENT = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		BS_START_SENT = 2'd0,
		BS_BYTE_SENT  = 2'd1,
		BS_BYTE_RCVD  = 2'd2,
		BS_OTHER      = 2'd3
	} bus_status_t;

	typedef enum logic [1:0] {
		FOL_NONE   = 2'd0,
		FOL_SINGLE = 2'd1,
		FOL_BURST  = 2'd2
	} follow_t;

	typedef enum logic [4:0] {
		PH_WR_DONE = 5'd0,
		PH_WR_DATA = 5'd1,
		PH_WR_REG  = 5'd2,
		PH_RD_LAST = 5'd3,
		PH_RD_ADDR = 5'd4,
		PH_B0      = 5'd16,
		PH_B1      = 5'd17,
		PH_B2      = 5'd18,
		PH_B3      = 5'd19,
		PH_B4      = 5'd20,
		PH_B5      = 5'd21,
		PH_B6      = 5'd22,
		PH_B7      = 5'd23,
		PH_B8      = 5'd24,
		PH_B9      = 5'd25,
		PH_B10     = 5'd26,
		PH_B11     = 5'd27,
		PH_B12     = 5'd28,
		PH_B13     = 5'd29
	} phase_t;

	localparam logic [WIDX_W-1:0] WIDX_SINGLE = 3'd6;

	typedef struct packed {
		logic [1:0]        func;
		logic [BYTE_W-1:0] reg_addr;
		logic [BYTE_W-1:0] write_data;
		logic [1:0]        bus_status;
		logic              ack_in;
		logic [BYTE_W-1:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic              load_valid;
		logic [BYTE_W-1:0] load_byte;
		logic              send_start;
		logic              send_stop;
		logic              ack_out;
		logic              busy_res;
		logic              word_valid;
		logic [WIDX_W-1:0] word_index;
		logic [WORD_W-1:0] word_value;
	} result_t;

	typedef struct packed {
		logic [ADDR_W-1:0] target_address;
		logic [BYTE_W-1:0] burst_first_register;
	} cfg_t;

	// word slot for a burst byte count that completes a word
	function automatic logic [WIDX_W-1:0] burst_word_index(input logic [3:0] n);
		logic [WIDX_W-1:0] idx;
		idx = '0;
		case (n)
			4'd0:    idx = 3'd5;
			4'd2:    idx = 3'd4;
			4'd4:    idx = 3'd3;
			4'd8:    idx = 3'd2;
			4'd10:   idx = 3'd1;
			4'd12:   idx = 3'd0;
			default: idx = '0;
		endcase
		return idx;
	endfunction

endpackage

`default_nettype wire

### rtl/i2csbr_cfg.sv
// ----------------------------------------------------------------------------
// i2csbr_cfg
// APB register file: device address and burst start register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2csbr_cfg
	import i2csbr_pkg::*;
#(
	parameter logic [ADDR_W-1:0] TARGET_RST = TARGET_ADDRESS_RST,
	parameter logic [BYTE_W-1:0] BURST_RST  = BURST_FIRST_RST
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [PADDR_W-1:0]  paddr,
	input  wire [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [ADDR_W-1:0] target_q;
	logic [BYTE_W-1:0] burst_q;
	logic              wr_en;
	logic              sel_burst;

	assign pready    = 1'b1;
	assign wr_en     = psel & penable & pwrite;
	assign sel_burst = (paddr[2] == REG_BURST_FIRST[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RST;
			burst_q  <= BURST_RST;
		end else if (wr_en) begin
			if (sel_burst) begin
				burst_q <= pwdata[BYTE_W-1:0];
			end else begin
				target_q <= pwdata[ADDR_W-1:0];
			end
		end
	end

	always_comb begin
		if (sel_burst) begin
			prdata = {{(PDATA_W-BYTE_W){1'b0}}, burst_q};
		end else begin
			prdata = {{(PDATA_W-ADDR_W){1'b0}}, target_q};
		end
	end

	assign cfg.target_address       = target_q;
	assign cfg.burst_first_register = burst_q;

endmodule

`default_nettype wire

### rtl/i2csbr_fsm.sv
// ----------------------------------------------------------------------------
// i2csbr_fsm
// Phase machine: one command or bus event per step, one result per step.
// ----------------------------------------------------------------------------
`default_nettype none

module i2csbr_fsm
	import i2csbr_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        step,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output result_t    res
);

	phase_t            phase_q, phase_d;
	logic              rd_dir_q, rd_dir_d;
	logic              busy_q, busy_d;
	follow_t           follow_q, follow_d;
	logic [BYTE_W-1:0] held_reg_q, held_reg_d;
	logic [BYTE_W-1:0] held_data_q, held_data_d;
	logic [BYTE_W-1:0] high_q, high_d;
	logic              in_burst;
	logic [3:0]        n;

	assign in_burst = phase_q[4] && (phase_q[3:0] <= 4'd13);
	assign n        = phase_q[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WR_DONE;
			rd_dir_q    <= 1'b0;
			busy_q      <= 1'b0;
			follow_q    <= FOL_NONE;
			held_reg_q  <= '0;
			held_data_q <= '0;
			high_q      <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			rd_dir_q    <= rd_dir_d;
			busy_q      <= busy_d;
			follow_q    <= follow_d;
			held_reg_q  <= held_reg_d;
			held_data_q <= held_data_d;
			high_q      <= high_d;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		rd_dir_d    = rd_dir_q;
		busy_d      = busy_q;
		follow_d    = follow_q;
		held_reg_d  = held_reg_q;
		held_data_d = held_data_q;
		high_d      = high_q;
		res         = '0;

		if (item.func != FN_EVENT) begin
			if (!busy_q) begin
				rd_dir_d = 1'b0;
				busy_d   = 1'b1;
				unique case (item.func)
					FN_WRITE: begin
						held_reg_d  = item.reg_addr;
						held_data_d = item.write_data;
						phase_d     = PH_WR_REG;
						follow_d    = FOL_NONE;
					end
					FN_READ: begin
						held_reg_d = item.reg_addr;
						phase_d    = PH_WR_DATA;
						follow_d   = FOL_SINGLE;
					end
					default: begin
						held_reg_d = cfg.burst_first_register;
						phase_d    = PH_WR_DATA;
						follow_d   = FOL_BURST;
					end
				endcase
				res.send_start = 1'b1;
			end
		end else begin
			unique case (item.bus_status)
				BS_START_SENT: begin
					res.load_valid = 1'b1;
					res.load_byte  = {cfg.target_address, rd_dir_q};
				end
				BS_BYTE_SENT: begin
					if (!item.ack_in) begin
						res.send_start = 1'b1;
						res.send_stop  = 1'b1;
					end else begin
						case (phase_q)
							PH_RD_ADDR: phase_d = PH_RD_LAST;
							PH_WR_REG: begin
								res.load_valid = 1'b1;
								res.load_byte  = held_reg_q;
								phase_d        = PH_WR_DATA;
							end
							PH_WR_DATA: begin
								res.load_valid = 1'b1;
								res.load_byte  = (follow_q == FOL_NONE) ? held_data_q
								                                        : held_reg_q;
								phase_d        = PH_WR_DONE;
							end
							PH_WR_DONE: begin
								res.send_stop = 1'b1;
								if (follow_q != FOL_NONE) begin
									res.send_start = 1'b1;
									rd_dir_d       = 1'b1;
									phase_d        = (follow_q == FOL_SINGLE) ? PH_RD_ADDR
									                                          : PH_B13;
									follow_d       = FOL_NONE;
								end else begin
									busy_d = 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				BS_BYTE_RCVD: begin
					if (in_burst) begin
						if (n == 4'd0) begin
							res.word_valid = 1'b1;
							res.word_index = burst_word_index(n);
							res.word_value = {high_q, item.rx_byte};
							busy_d         = 1'b0;
							res.send_stop  = 1'b1;
						end else begin
							// temperature pair is dropped
							if (n == 4'd6 || n == 4'd7) begin
							end else if (n[0]) begin
								high_d = item.rx_byte;
							end else begin
								res.word_valid = 1'b1;
								res.word_index = burst_word_index(n);
								res.word_value = {high_q, item.rx_byte};
							end
							phase_d     = phase_t'(phase_q - 5'd1);
							res.ack_out = 1'b1;
						end
					end else begin
						res.word_valid = 1'b1;
						res.word_index = WIDX_SINGLE;
						res.word_value = {{(WORD_W-BYTE_W){1'b0}}, item.rx_byte};
						busy_d         = 1'b0;
						res.send_stop  = 1'b1;
					end
				end
				default: ;
			endcase
		end

		res.busy_res = busy_d;
	end

endmodule

`default_nettype wire

### rtl/i2c_sensor_burst_read_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_sensor_burst_read_sequencer
// I2C master command and bus event sequencer for register access and a
// fourteen-byte sensor burst read.
// ----------------------------------------------------------------------------
// Each input transaction (command or bus event) yields exactly one result
// transaction. The transaction is captured in an input register, the phase
// machine handles it and writes the result register. A new transaction is
// taken every cycle as long as the result register drains; with out_stall
// high one more transaction is held in the input register before in_stall
// rises. Configuration writes go through the APB port and should only happen
// while no transaction is in flight.
`default_nettype none

module i2c_sensor_burst_read_sequencer
	import i2csbr_pkg::*;
#(
	parameter logic [ADDR_W-1:0] TARGET_RST = TARGET_ADDRESS_RST,
	parameter logic [BYTE_W-1:0] BURST_RST  = BURST_FIRST_RST
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [PADDR_W-1:0]  paddr,
	input  wire [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire [1:0]          func,
	input  wire [BYTE_W-1:0]   reg_addr,
	input  wire [BYTE_W-1:0]   write_data,
	input  wire [1:0]          bus_status,
	input  wire                ack_in,
	input  wire [BYTE_W-1:0]   rx_byte,
	output logic               out_valid,
	input  wire                out_stall,
	output logic               load_valid,
	output logic [BYTE_W-1:0]  load_byte,
	output logic               send_start,
	output logic               send_stop,
	output logic               ack_out,
	output logic               busy_res,
	output logic               word_valid,
	output logic [WIDX_W-1:0]  word_index,
	output logic [WORD_W-1:0]  word_value
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	logic    take_in;

	i2csbr_cfg #(
		.TARGET_RST(TARGET_RST),
		.BURST_RST (BURST_RST)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign advance  = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign take_in  = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take_in | (valid_s1 & ~advance);
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.func       <= func;
			item_s1.reg_addr   <= reg_addr;
			item_s1.write_data <= write_data;
			item_s1.bus_status <= bus_status;
			item_s1.ack_in     <= ack_in;
			item_s1.rx_byte    <= rx_byte;
		end
	end

	i2csbr_fsm u_fsm (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.item  (item_s1),
		.cfg   (cfg),
		.res   (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid  = valid_s2;
	assign load_valid = res_s2.load_valid;
	assign load_byte  = res_s2.load_byte;
	assign send_start = res_s2.send_start;
	assign send_stop  = res_s2.send_stop;
	assign ack_out    = res_s2.ack_out;
	assign busy_res   = res_s2.busy_res;
	assign word_valid = res_s2.word_valid;
	assign word_index = res_s2.word_index;
	assign word_value = res_s2.word_value;

endmodule

`default_nettype wire
